>>> rtl/core/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg - momentum direction classifier shared definitions
// Symbol codes for small signed components and the status bundle passed
// from the iterative arithmetic unit to the top-level control.
// ----------------------------------------------------------------------------
package mdc_pkg;

    // Symbol code: 0..4 stand for -2..+2, one extra code for out of range
    typedef logic [2:0] code_t;

    localparam code_t CODE_OFFSET       = 3'd2;
    localparam code_t CODE_OUT_OF_RANGE = 3'd5;

    // Status of the iterative unit
    typedef struct packed {
        logic busy;     // sequencer is working on an item
        logic done;     // one-cycle pulse, results are valid from here on
    } unit_status_t;

endpackage

>>> rtl/core/mdc_unit.sv
// ----------------------------------------------------------------------------
// mdc_unit - iterative gcd / divide / square-sum unit
// A small sequencer drives one shared subtractor: binary gcd over the three
// magnitudes, then, if the gcd exceeds one, restoring division of each
// magnitude by the gcd. Squared length is accumulated first, through one multiplier.
// ----------------------------------------------------------------------------
module mdc_unit #(
    parameter int W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [2:0][W-1:0]     mag,
    output mdc_pkg::unit_status_t status,
    output logic [2:0][W-1:0]     quo,
    output logic                  reduce,
    output logic [((2*W > 17) ? 2*W : 17)-1:0] len
);

    localparam int LEN_W = (2 * W > 17) ? 2 * W : 17;
    localparam int CNT_W = $clog2(W);
    localparam int K_W   = $clog2(W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQR,
        ST_GCD,
        ST_DIV
    } state_t;

    state_t                 state_reg;
    logic [1:0]             idx_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [K_W-1:0]         k_reg;
    logic                   pass_reg;
    logic [W-1:0]           a_reg;
    logic [W-1:0]           b_reg;
    logic [W-1:0]           g_reg;
    logic [W-1:0]           rem_reg;
    logic [W-1:0]           dvd_reg;
    logic [2:0][W-1:0]      quo_reg;
    logic                   reduce_reg;
    logic                   done_reg;
    logic [LEN_W-1:0]       len_reg;

    logic [W-1:0]           mag_sel;
    logic [2*W-1:0]         sq;
    logic [W-1:0]           gcd_res;
    logic [W-1:0]           rem_cur;
    logic [W-1:0]           dvd_cur;
    logic [W-1:0]           shifted;
    logic [W:0]             sub_lhs;
    logic [W:0]             sub_rhs;
    logic [W:0]             diff;
    logic                   borrow;
    logic                   qbit;
    logic [W-1:0]           rem_next;
    logic [W-1:0]           dvd_next;

    // Single read port into the magnitudes
    assign mag_sel = mag[idx_reg];

    // Square of the selected magnitude
    assign sq = {{W{1'b0}}, mag_sel} * {{W{1'b0}}, mag_sel};

    // Gcd of a pair once one side reached zero, with common twos restored
    assign gcd_res = W'((a_reg | b_reg) << k_reg);

    // Division step operands; first step of a component takes fresh dividend
    assign rem_cur = (cnt_reg == '0) ? '0 : rem_reg;
    assign dvd_cur = (cnt_reg == '0) ? mag_sel : dvd_reg;
    assign shifted = {rem_cur[W-2:0], dvd_cur[W-1]};

    // Shared subtractor
    always_comb
    begin
        if (state_reg == ST_DIV)
        begin
            sub_lhs = {1'b0, shifted};
            sub_rhs = {1'b0, g_reg};
        end
        else
        begin
            sub_lhs = {1'b0, a_reg};
            sub_rhs = {1'b0, b_reg};
        end
    end

    assign diff   = sub_lhs - sub_rhs;
    assign borrow = diff[W];

    // Restoring division step
    assign qbit     = ~borrow;
    assign rem_next = qbit ? diff[W-1:0] : shifted;
    assign dvd_next = {dvd_cur[W-2:0], qbit};

    // Sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            idx_reg    <= '0;
            cnt_reg    <= '0;
            k_reg      <= '0;
            pass_reg   <= 1'b0;
            a_reg      <= '0;
            b_reg      <= '0;
            g_reg      <= '0;
            rem_reg    <= '0;
            dvd_reg    <= '0;
            quo_reg    <= '0;
            reduce_reg <= 1'b0;
            done_reg   <= 1'b0;
            len_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        len_reg   <= '0;
                        idx_reg   <= '0;
                        state_reg <= ST_SQR;
                    end
                end

                // one square per cycle
                ST_SQR:
                begin
                    len_reg <= len_reg + LEN_W'(sq);
                    if (idx_reg == 2'd2)
                    begin
                        a_reg     <= mag[0];
                        b_reg     <= mag[1];
                        k_reg     <= '0;
                        pass_reg  <= 1'b0;
                        idx_reg   <= '0;
                        state_reg <= ST_GCD;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 2'd1;
                    end
                end

                // binary gcd, one step per cycle
                ST_GCD:
                begin
                    if (a_reg == '0 || b_reg == '0)
                    begin
                        if (!pass_reg)
                        begin
                            a_reg    <= gcd_res;
                            b_reg    <= mag[2];
                            k_reg    <= '0;
                            pass_reg <= 1'b1;
                        end
                        else
                        begin
                            g_reg <= gcd_res;
                            if (gcd_res <= W'(1))
                            begin
                                reduce_reg <= 1'b0;
                                done_reg   <= 1'b1;
                                state_reg  <= ST_IDLE;
                            end
                            else
                            begin
                                reduce_reg <= 1'b1;
                                idx_reg    <= '0;
                                cnt_reg    <= '0;
                                state_reg  <= ST_DIV;
                            end
                        end
                    end
                    else if (!a_reg[0] && !b_reg[0])
                    begin
                        a_reg <= a_reg >> 1;
                        b_reg <= b_reg >> 1;
                        k_reg <= k_reg + 1'b1;
                    end
                    else if (!a_reg[0])
                    begin
                        a_reg <= a_reg >> 1;
                    end
                    else if (!b_reg[0])
                    begin
                        b_reg <= b_reg >> 1;
                    end
                    else if (borrow)
                    begin
                        // keep the larger value in a
                        a_reg <= b_reg;
                        b_reg <= a_reg;
                    end
                    else
                    begin
                        a_reg <= diff[W-1:0];
                    end
                end

                // restoring division, one quotient bit per cycle
                ST_DIV:
                begin
                    rem_reg <= rem_next;
                    dvd_reg <= dvd_next;
                    if (cnt_reg == CNT_W'(W - 1))
                    begin
                        quo_reg[idx_reg] <= dvd_next;
                        cnt_reg          <= '0;
                        if (idx_reg == 2'd2)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = done_reg;
    assign quo         = quo_reg;
    assign reduce      = reduce_reg;
    assign len         = len_reg;

endmodule

>>> rtl/core/momentum_direction_classifier.sv
// ----------------------------------------------------------------------------
// momentum_direction_classifier - lattice momentum direction and codes
// Reduces an integer momentum by the gcd of its magnitudes, codes raw and
// reduced components, flags allowed rays and gives the squared length.
// ----------------------------------------------------------------------------
// Sequence: the squares of the three magnitudes, two binary-gcd passes, and
//   a division of each magnitude when the gcd exceeds one, then capture of
//   the result in the output register.
// Throughput: one beat at a time; the next beat is taken once the result of
//   the current one is in the output register, so the unit and result_stall set it.
// Reset: rst_n clears control and the output register; no valid result after.
module momentum_direction_classifier #(
    parameter int COMP_WIDTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [COMP_WIDTH-1:0] comp_x,
    input  logic [COMP_WIDTH-1:0] comp_y,
    input  logic [COMP_WIDTH-1:0] comp_z,

    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [COMP_WIDTH-1:0] dir_x,
    output logic [COMP_WIDTH-1:0] dir_y,
    output logic [COMP_WIDTH-1:0] dir_z,
    output logic [2:0]            type_x,
    output logic [2:0]            type_y,
    output logic [2:0]            type_z,
    output logic [2:0]            raw_code_x,
    output logic [2:0]            raw_code_y,
    output logic [2:0]            raw_code_z,
    output logic                  ray_allowed,
    output logic [15:0]           length_squared
);

    localparam int W     = COMP_WIDTH;
    localparam int LEN_W = (2 * W > 17) ? 2 * W : 17;

    localparam logic signed [W-1:0] NEG_TWO = W'(-2);
    localparam logic signed [W-1:0] POS_TWO = W'(2);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t                     state_reg;
    logic                       start_reg;
    logic [2:0][W-1:0]          comp_reg;
    logic                       result_valid_reg;
    logic [2:0][W-1:0]          dir_reg;
    logic [2:0][2:0]            type_reg;
    logic [2:0][2:0]            raw_reg;
    logic                       ray_reg;
    logic [15:0]                len_out_reg;

    logic [2:0][W-1:0]          mag;
    logic [2:0][W-1:0]          quo;
    logic [2:0][W-1:0]          dir_next;
    logic [2:0][2:0]            type_next;
    logic [2:0][2:0]            raw_next;
    logic                       ray_next;
    logic [15:0]                len_next;
    logic                       reduce;
    logic [LEN_W-1:0]           len;
    mdc_pkg::unit_status_t      unit_status;
    logic                       accept;
    logic                       slot_free;
    logic                       load;

    // Magnitude of a two's complement component
    function automatic logic [W-1:0] mag_of(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    // Symbol code of a signed component
    function automatic mdc_pkg::code_t code_of(input logic signed [W-1:0] v);
        if (v >= NEG_TWO && v <= POS_TWO)
            return mdc_pkg::code_t'(v[2:0] + mdc_pkg::CODE_OFFSET);
        else
            return mdc_pkg::CODE_OUT_OF_RANGE;
    endfunction

    // Handshake
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign slot_free  = !result_valid_reg || !result_stall;
    assign load       = slot_free &&
                        ((state_reg == ST_RUN && unit_status.done) ||
                         state_reg == ST_HOLD);

    // Magnitudes of the captured components
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mag[i] = mag_of(comp_reg[i]);
    end

    mdc_unit #(
        .W (W)
    ) u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .mag    (mag),
        .status (unit_status),
        .quo    (quo),
        .reduce (reduce),
        .len    (len)
    );

    // Result assembly: signed direction, codes, ray flag, saturated length
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (reduce)
                dir_next[i] = comp_reg[i][W-1] ? (~quo[i] + 1'b1) : quo[i];
            else
                dir_next[i] = comp_reg[i];
            type_next[i] = code_of(dir_next[i]);
            raw_next[i]  = code_of(comp_reg[i]);
        end
        ray_next = !((mag[0] != '0 && mag[1] != '0 && mag[0] != mag[1]) ||
                     (mag[0] != '0 && mag[2] != '0 && mag[0] != mag[2]) ||
                     (mag[1] != '0 && mag[2] != '0 && mag[1] != mag[2]));
        len_next = (len > LEN_W'(16'hFFFF)) ? 16'hFFFF : len[15:0];
    end

    // Control state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            start_reg        <= 1'b0;
            comp_reg         <= '0;
            result_valid_reg <= 1'b0;
            dir_reg          <= '0;
            type_reg         <= '0;
            raw_reg          <= '0;
            ray_reg          <= 1'b0;
            len_out_reg      <= '0;
        end
        else
        begin
            start_reg <= 1'b0;

            if (load)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;

            if (load)
            begin
                dir_reg     <= dir_next;
                type_reg    <= type_next;
                raw_reg     <= raw_next;
                ray_reg     <= ray_next;
                len_out_reg <= len_next;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        comp_reg  <= {comp_z, comp_y, comp_x};
                        start_reg <= 1'b1;
                        state_reg <= ST_RUN;
                    end
                end

                ST_RUN:
                begin
                    if (unit_status.done)
                        state_reg <= slot_free ? ST_IDLE : ST_HOLD;
                end

                ST_HOLD:
                begin
                    if (slot_free)
                        state_reg <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid   = result_valid_reg;
    assign dir_x          = dir_reg[0];
    assign dir_y          = dir_reg[1];
    assign dir_z          = dir_reg[2];
    assign type_x         = type_reg[0];
    assign type_y         = type_reg[1];
    assign type_z         = type_reg[2];
    assign raw_code_x     = raw_reg[0];
    assign raw_code_y     = raw_reg[1];
    assign raw_code_z     = raw_reg[2];
    assign ray_allowed    = ray_reg;
    assign length_squared = len_out_reg;

    // The unit works only for an item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        unit_status.busy |-> state_reg == ST_RUN)
        else $error("unit busy without an item in flight");

    // A finished item is reported only while the control waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        unit_status.done |-> state_reg == ST_RUN)
        else $error("unit result with no item pending");

    // An accepted beat starts the unit by way of start_reg
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 unit_status.busy)
        else $error("accepted beat did not start the unit");

    // A zero-length result is the zero vector on an allowed ray
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && length_squared == 16'd0) |->
            (dir_x == '0 && dir_y == '0 && dir_z == '0 && ray_allowed))
        else $error("zero vector result is inconsistent");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb - momentum direction classifier testbench
// Drives lattice momenta through the valid/stall input channel and checks
// every result beat, field by field, against a hand-written or predicted record.
// A short table of corner vectors comes first, then random vectors shaped
// toward rays, common factors and extremes, under random sender bursts and
// receiver stall patterns, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W             = 8;
    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_ITEMS  = 900;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int TAIL_CYCLES   = 200;
    localparam int LONG_HOLD     = 400;

    // Symbol codes for the small component values
    localparam mdc_pkg::code_t SYM_NEG2 = mdc_pkg::code_t'(int'(mdc_pkg::CODE_OFFSET) - 2);
    localparam mdc_pkg::code_t SYM_NEG1 = mdc_pkg::code_t'(int'(mdc_pkg::CODE_OFFSET) - 1);
    localparam mdc_pkg::code_t SYM_ZERO = mdc_pkg::CODE_OFFSET;
    localparam mdc_pkg::code_t SYM_POS1 = mdc_pkg::code_t'(int'(mdc_pkg::CODE_OFFSET) + 1);
    localparam mdc_pkg::code_t SYM_POS2 = mdc_pkg::code_t'(int'(mdc_pkg::CODE_OFFSET) + 2);
    localparam mdc_pkg::code_t SYM_OUT  = mdc_pkg::CODE_OUT_OF_RANGE;

    typedef struct packed {
        logic [W-1:0]   dir_x;
        logic [W-1:0]   dir_y;
        logic [W-1:0]   dir_z;
        mdc_pkg::code_t type_x;
        mdc_pkg::code_t type_y;
        mdc_pkg::code_t type_z;
        mdc_pkg::code_t raw_x;
        mdc_pkg::code_t raw_y;
        mdc_pkg::code_t raw_z;
        logic           ray;
        logic [15:0]    len_sq;
    } direction_rec_t;

    typedef struct packed {
        int             x;
        int             y;
        int             z;
        bit             typed;
        direction_rec_t known;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         item_valid = 1'b0;
    logic         item_stall;
    logic [W-1:0] comp_x = '0;
    logic [W-1:0] comp_y = '0;
    logic [W-1:0] comp_z = '0;
    logic         result_valid;
    logic         result_stall = 1'b0;
    logic [W-1:0] dir_x;
    logic [W-1:0] dir_y;
    logic [W-1:0] dir_z;
    logic [2:0]   type_x;
    logic [2:0]   type_y;
    logic [2:0]   type_z;
    logic [2:0]   raw_code_x;
    logic [2:0]   raw_code_y;
    logic [2:0]   raw_code_z;
    logic         ray_allowed;
    logic [15:0]  length_squared;

    // Expectation that travels with the beat on offer (table rows only)
    bit             beat_typed = 1'b0;
    direction_rec_t beat_known = '0;

    direction_rec_t pending_dirs[$];
    stim_row_t      directed_table [DIRECTED_ROWS];
    int             fail_count = 0;
    bit             random_started = 1'b0;

    momentum_direction_classifier #(
        .COMP_WIDTH(W)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .comp_x         (comp_x),
        .comp_y         (comp_y),
        .comp_z         (comp_z),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .dir_x          (dir_x),
        .dir_y          (dir_y),
        .dir_z          (dir_z),
        .type_x         (type_x),
        .type_y         (type_y),
        .type_z         (type_z),
        .raw_code_x     (raw_code_x),
        .raw_code_y     (raw_code_y),
        .raw_code_z     (raw_code_z),
        .ray_allowed    (ray_allowed),
        .length_squared (length_squared)
    );

    always #10 clk = ~clk;

    // Hard stop in case the block hangs
    initial
    begin
        #15ms;
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Direction predictor
    // ------------------------------------------------------------------------
    function automatic int euclid_gcd(int a, int b);
        int t;
        while (b != 0)
        begin
            t = b;
            b = a % t;
            a = t;
        end
        return a;
    endfunction

    function automatic mdc_pkg::code_t symbol_of(int v);
        if (v >= -2 && v <= 2)
            return mdc_pkg::code_t'(v + int'(mdc_pkg::CODE_OFFSET));
        return SYM_OUT;
    endfunction

    function automatic direction_rec_t classify_momentum(logic [W-1:0] x, logic [W-1:0] y,
                                                         logic [W-1:0] z);
        int             comp [3];
        int             mag [3];
        int             reduced [3];
        int             divisor;
        int             ray_mag;
        bit             on_ray;
        longint         len;
        direction_rec_t r;
        comp[0] = $signed(x);
        comp[1] = $signed(y);
        comp[2] = $signed(z);
        ray_mag = 0;
        on_ray  = 1'b1;
        len     = 0;
        for (int i = 0; i < 3; i++)
            mag[i] = (comp[i] < 0) ? -comp[i] : comp[i];
        divisor = euclid_gcd(euclid_gcd(mag[0], mag[1]), mag[2]);
        for (int i = 0; i < 3; i++)
        begin
            // gcd of 0 or 1 leaves the vector as it is, so -2^(W-1) passes through
            if (divisor <= 1)
                reduced[i] = comp[i];
            else
                reduced[i] = (comp[i] < 0) ? -(mag[i] / divisor) : mag[i] / divisor;
            if (mag[i] != 0)
            begin
                if (ray_mag == 0)
                    ray_mag = mag[i];
                else if (mag[i] != ray_mag)
                    on_ray = 1'b0;
            end
            len += longint'(mag[i]) * longint'(mag[i]);
        end
        if (len > 65535)
            len = 65535;
        r.dir_x  = W'(reduced[0]);
        r.dir_y  = W'(reduced[1]);
        r.dir_z  = W'(reduced[2]);
        r.type_x = symbol_of(reduced[0]);
        r.type_y = symbol_of(reduced[1]);
        r.type_z = symbol_of(reduced[2]);
        r.raw_x  = symbol_of(comp[0]);
        r.raw_y  = symbol_of(comp[1]);
        r.raw_z  = symbol_of(comp[2]);
        r.ray    = on_ray;
        r.len_sq = 16'(len);
        return r;
    endfunction

    // Hand-written expectation for a table row
    function automatic direction_rec_t rec_of(int dx, int dy, int dz,
                                              mdc_pkg::code_t tx, mdc_pkg::code_t ty,
                                              mdc_pkg::code_t tz,
                                              mdc_pkg::code_t rx, mdc_pkg::code_t ry,
                                              mdc_pkg::code_t rz,
                                              bit ray, int len);
        direction_rec_t r;
        r.dir_x  = W'(dx);
        r.dir_y  = W'(dy);
        r.dir_z  = W'(dz);
        r.type_x = tx;
        r.type_y = ty;
        r.type_z = tz;
        r.raw_x  = rx;
        r.raw_y  = ry;
        r.raw_z  = rz;
        r.ray    = ray;
        r.len_sq = 16'(len);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic signed [16:0] want,
                               input logic signed [16:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        direction_rec_t want;
        if (rst_n)
        begin
            // record the expectation of each accepted input beat
            if (item_valid && !item_stall)
                pending_dirs.push_back(beat_typed ? beat_known
                                                  : classify_momentum(comp_x, comp_y, comp_z));
            // compare each accepted result beat with the oldest expectation
            if (result_valid && !result_stall)
            begin
                if (pending_dirs.size() == 0)
                begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    want = pending_dirs.pop_front();
                    check_field("dir_x", $signed(want.dir_x), $signed(dir_x));
                    check_field("dir_y", $signed(want.dir_y), $signed(dir_y));
                    check_field("dir_z", $signed(want.dir_z), $signed(dir_z));
                    check_field("type_x", want.type_x, type_x);
                    check_field("type_y", want.type_y, type_y);
                    check_field("type_z", want.type_z, type_z);
                    check_field("raw_code_x", want.raw_x, raw_code_x);
                    check_field("raw_code_y", want.raw_y, raw_code_y);
                    check_field("raw_code_z", want.raw_z, raw_code_z);
                    check_field("ray_allowed", want.ray, ray_allowed);
                    check_field("length_squared", want.len_sq, length_squared);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Offer one beat and hold it until accepted; valid stays high on return
    task automatic offer_beat(input logic [W-1:0] x, input logic [W-1:0] y,
                              input logic [W-1:0] z, input bit typed,
                              input direction_rec_t known);
        item_valid <= 1'b1;
        comp_x     <= x;
        comp_y     <= y;
        comp_z     <= z;
        beat_typed <= typed;
        beat_known <= known;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task automatic wait_drained(input int max_cycles);
        int n;
        n = 0;
        @(posedge clk);
        while (pending_dirs.size() != 0 && n < max_cycles)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    // Random momentum, shaped toward rays, common factors and corners
    task automatic make_momentum(output logic [W-1:0] x, output logic [W-1:0] y,
                                 output logic [W-1:0] z);
        int v [3];
        int shape;
        int k;
        int m;
        int s;
        int corner_vals [8];
        corner_vals = '{-128, -127, -2, -1, 0, 1, 2, 127};
        shape = $urandom_range(0, 9);
        k     = $urandom_range(2, 42);
        m     = $urandom_range(1, 128);
        for (int i = 0; i < 3; i++)
        begin
            case (shape)
                0, 1, 2: v[i] = $signed(W'($urandom));
                3, 4:    v[i] = int'($urandom_range(0, 6)) - 3;
                5, 6, 7: v[i] = k * (int'($urandom_range(0, 6)) - 3);
                8:
                begin
                    // ray: each component is 0 or +/-m; +128 does not fit
                    s = $urandom_range(0, 2);
                    v[i] = (s == 0) ? 0 : ((s == 1 && m < 128) ? m : -m);
                end
                default: v[i] = corner_vals[$urandom_range(0, 7)];
            endcase
        end
        x = W'(v[0]);
        y = W'(v[1]);
        z = W'(v[2]);
    endtask

    initial
    begin : sender
        logic [W-1:0] rx;
        logic [W-1:0] ry;
        logic [W-1:0] rz;
        int           gap;
        int           burst;
        int           sent;

        directed_table = '{
            // zero vector: gcd 0, all codes zero, still a ray
            '{0, 0, 0, 1'b1, rec_of(0, 0, 0, SYM_ZERO, SYM_ZERO, SYM_ZERO,
                                    SYM_ZERO, SYM_ZERO, SYM_ZERO, 1'b1, 0)},
            '{-128, -128, -128, 1'b1, rec_of(-1, -1, -1, SYM_NEG1, SYM_NEG1, SYM_NEG1,
                                             SYM_OUT, SYM_OUT, SYM_OUT, 1'b1, 49152)},
            '{127, 127, 127, 1'b1, rec_of(1, 1, 1, SYM_POS1, SYM_POS1, SYM_POS1,
                                          SYM_OUT, SYM_OUT, SYM_OUT, 1'b1, 48387)},
            // most negative component with gcd 1 passes through
            '{-128, 127, 0, 1'b1, rec_of(-128, 127, 0, SYM_OUT, SYM_OUT, SYM_ZERO,
                                         SYM_OUT, SYM_OUT, SYM_ZERO, 1'b0, 32513)},
            '{2, -2, 2, 1'b1, rec_of(1, -1, 1, SYM_POS1, SYM_NEG1, SYM_POS1,
                                     SYM_POS2, SYM_NEG2, SYM_POS2, 1'b1, 12)},
            '{1, -1, 0, 1'b1, rec_of(1, -1, 0, SYM_POS1, SYM_NEG1, SYM_ZERO,
                                     SYM_POS1, SYM_NEG1, SYM_ZERO, 1'b1, 2)},
            '{0, 0, -128, 1'b1, rec_of(0, 0, -1, SYM_ZERO, SYM_ZERO, SYM_NEG1,
                                       SYM_ZERO, SYM_ZERO, SYM_OUT, 1'b1, 16384)},
            '{-1, -1, -1, 1'b1, rec_of(-1, -1, -1, SYM_NEG1, SYM_NEG1, SYM_NEG1,
                                       SYM_NEG1, SYM_NEG1, SYM_NEG1, 1'b1, 3)},
            // the rest go through the predictor
            '{4, 6, 0, 1'b0, '0},
            '{-6, 0, 9, 1'b0, '0},
            '{5, 0, 0, 1'b0, '0},
            '{0, -3, 0, 1'b0, '0},
            '{-2, -1, 2, 1'b0, '0},
            '{64, -32, 96, 1'b0, '0},
            '{127, -128, -1, 1'b0, '0},
            '{100, 100, -100, 1'b0, '0},
            '{3, 6, 9, 1'b0, '0},
            '{-128, 0, 64, 1'b0, '0},
            '{2, 0, 0, 1'b0, '0},
            '{0, 2, -2, 1'b0, '0},
            '{-127, 1, 0, 1'b0, '0},
            '{96, -64, -32, 1'b0, '0},
            '{7, 14, 21, 1'b0, '0},
            '{1, 2, 3, 1'b0, '0}
        };

        // reset
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, short random gaps
        foreach (directed_table[i])
        begin
            offer_beat(W'(directed_table[i].x), W'(directed_table[i].y),
                       W'(directed_table[i].z), directed_table[i].typed,
                       directed_table[i].known);
            gap = $urandom_range(0, 3);
            if (gap != 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        item_valid <= 1'b0;
        // sender pause until every result is back
        wait_drained(DRAIN_LIMIT);
        random_started <= 1'b1;

        // random bursts; one more full drain halfway through
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++)
            begin
                make_momentum(rx, ry, rz);
                offer_beat(rx, ry, rz, 1'b0, '0);
                sent++;
                if (sent == RANDOM_ITEMS / 2)
                begin
                    item_valid <= 1'b0;
                    wait_drained(DRAIN_LIMIT);
                end
            end
            if ($urandom_range(0, 2) != 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
        item_valid <= 1'b0;

        // drain and settle
        wait_drained(DRAIN_LIMIT);
        if (pending_dirs.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_dirs.size());
            fail_count++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver side: stall patterns, one long hold-off once random traffic runs
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int mode;
        int span;
        int tick;
        bit long_hold_done;
        tick           = 0;
        long_hold_done = 1'b0;
        forever
        begin
            if (random_started && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                repeat (LONG_HOLD)
                begin
                    @(posedge clk);
                    result_stall <= 1'b1;
                end
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(posedge clk);
                tick++;
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(0, 3) == 0);
                    2:       result_stall <= ($urandom_range(0, 3) != 0);
                    default: result_stall <= ((tick % 7) < 3);
                endcase
            end
        end
    end

endmodule

>>> filelist.f
rtl/core/mdc_pkg.sv
rtl/core/mdc_unit.sv
rtl/core/momentum_direction_classifier.sv
tb/tb.sv
